[design/wolf_phc_pkg.sv]
// ----------------------------------------------------------------------------
// wolf_phc_pkg
// Shared types, codes and helpers of the policy hill-climbing route learner.
// ----------------------------------------------------------------------------
package wolf_phc_pkg;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef enum logic [1:0] {
        RWD_REACH  = 2'd0,
        RWD_VOID   = 2'd1,
        RWD_LOOP   = 2'd2,
        RWD_MIDWAY = 2'd3
    } reward_kind_t;

    typedef enum logic [2:0] {
        REG_LEARNING_RATE = 3'd0,
        REG_DISCOUNT_RATE = 3'd1,
        REG_DELTA_WIN     = 3'd2,
        REG_DELTA_LOSE    = 3'd3,
        REG_ACTIVE_NODES  = 3'd4
    } reg_index_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_TGT, ST_TGT2, ST_LR, ST_NQ, ST_VIS,
        ST_MRD, ST_MLD, ST_MDIV, ST_MWR,
        ST_SRD, ST_SMP, ST_SMM, ST_SACC,
        ST_DEC, ST_DDIV, ST_URD, ST_UWR, ST_DONE
    } state_t;

    // rates above one count as one
    function automatic logic [16:0] cap_one(input logic [16:0] r);
        cap_one = (r > ONE_Q16) ? ONE_Q16 : r;
    endfunction

endpackage

[design/wolf_phc_route_learner_core.sv]
// ----------------------------------------------------------------------------
// wolf_phc_route_learner_core
// WoLF policy hill-climbing learner: Q update, mean policy, win/lose step,
// policy climb toward the greedy hop, one shared multiplier and divider.
// ----------------------------------------------------------------------------
//  channel   signals                                         direction
//  ------    ----------------------------------------------  ---------
//  event     start, busy, dest_index, hop_index, no_hop,     in, busy out
//            reward_kind, best_next_q, mobility_factor
//  result    done, new_q, greedy_hop, winning, skipped       out
//  config    psel, penable, pwrite, paddr, pwdata, prdata,   in/out
//            pready
//
//  After reset a clearing pass over all NODES*NODES entries loads the tables;
//  busy is high meanwhile, config transfers are taken as usual.
//  An event's run time is dominated by the 17-step shared divider run for
//  every mean policy entry. A skipped event goes from idle straight to
//  done. done pulses for one cycle; the receiver cannot stall, and busy
//  drops in the cycle after done.
module wolf_phc_route_learner_core
    import wolf_phc_pkg::*;
#(
    parameter int NODES   = 16,
    parameter int Q_WIDTH = 32
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         dest_index,
    input  logic [3:0]         hop_index,
    input  logic               no_hop,
    input  logic [1:0]         reward_kind,
    input  logic signed [31:0] best_next_q,
    input  logic signed [31:0] mobility_factor,
    output logic               done,
    output logic signed [31:0] new_q,
    output logic [3:0]         greedy_hop,
    output logic               winning,
    output logic               skipped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int NW  = $clog2(NODES);
    localparam int AW  = $clog2(NODES * NODES);
    localparam int QB  = (Q_WIDTH < 38) ? Q_WIDTH : 38;
    localparam int BW  = (QB + 1 > 32) ? QB + 1 : 32;
    localparam int PW  = 18 + BW;
    localparam int SW  = PW + 1;
    localparam int AC  = PW + NW + 1;
    localparam logic [16:0] UNI = 17'((65536 + (NODES - 1) / 2) / (NODES - 1));
    localparam logic [NW-1:0] LAST = NW'(NODES - 1);
    localparam logic signed [SW-1:0] Q_HI = {{(SW-QB+1){1'b0}}, {(QB-1){1'b1}}};
    localparam logic signed [SW-1:0] Q_LO = ~Q_HI;
    localparam logic signed [SW-1:0] O_HI = SW'(64'sh7FFFFFFF);
    localparam logic signed [SW-1:0] O_LO = ~O_HI;

    // index taken modulo NODES, at most five subtractions of a narrow value
    function automatic logic [NW-1:0] mod_nodes(input logic [3:0] x);
        logic [8:0] v;
        v = {5'd0, x};
        for (int i = 0; i < 5; i++) begin
            if (v >= 9'(NODES)) begin
                v = v - 9'(NODES);
            end
        end
        mod_nodes = v[NW-1:0];
    endfunction

    function automatic logic signed [QB-1:0] sat_q(input logic signed [SW-1:0] v);
        if (v > Q_HI) begin
            sat_q = Q_HI[QB-1:0];
        end else if (v < Q_LO) begin
            sat_q = Q_LO[QB-1:0];
        end else begin
            sat_q = v[QB-1:0];
        end
    endfunction

    // ---------------- configuration ----------------
    logic [16:0] lr_reg, dr_reg, dw_reg, dl_reg;
    logic [4:0]  an_reg;
    logic        cfg_wr;
    reg_index_t  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lr_reg <= 17'd32768;
            dr_reg <= 17'd58982;
            dw_reg <= 17'd655;
            dl_reg <= 17'd1311;
            an_reg <= 5'd16;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LEARNING_RATE: lr_reg <= pwdata[16:0];
                REG_DISCOUNT_RATE: dr_reg <= pwdata[16:0];
                REG_DELTA_WIN:     dw_reg <= pwdata[16:0];
                REG_DELTA_LOSE:    dl_reg <= pwdata[16:0];
                REG_ACTIVE_NODES:  an_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_LEARNING_RATE: prdata = {15'd0, lr_reg};
            REG_DISCOUNT_RATE: prdata = {15'd0, dr_reg};
            REG_DELTA_WIN:     prdata = {15'd0, dw_reg};
            REG_DELTA_LOSE:    prdata = {15'd0, dl_reg};
            REG_ACTIVE_NODES:  prdata = {27'd0, an_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- tables ----------------
    logic signed [QB-1:0] q_mem [NODES*NODES];
    logic [16:0]          p_mem [NODES*NODES];
    logic [16:0]          m_mem [NODES*NODES];
    logic [15:0]          v_mem [NODES];

    state_t state_reg, state_next;
    logic [NW-1:0] row_reg, col_reg, greedy_reg;
    logic [AW-1:0] addr;
    logic signed [QB-1:0] q_rd_reg, nq_reg, target_reg, best_q_reg;
    logic [16:0] p_rd_reg, m_rd_reg, dq_reg, rem_reg, den_reg, dec_reg, step_reg;
    logic [15:0] v_rd_reg, vis_reg;
    logic [4:0]  cnt_reg;
    logic        neg_reg, skip_reg, win_reg;
    logic [1:0]  kind_reg;
    logic signed [31:0] best_reg, mob_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AC-1:0] accp_reg, accm_reg;

    assign addr = AW'(row_reg) * AW'(NODES) + AW'(col_reg);

    // shared multiplier, operands chosen per state
    logic signed [17:0]   mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p, rnd;
    assign mul_p = mul_a * mul_b;
    assign rnd   = (prod_reg + PW'(32768)) >>> 16;

    // shared restoring divider step
    logic [16:0] rem_sh;
    logic        q_bit;
    assign rem_sh = {rem_reg[15:0], dq_reg[16]};
    assign q_bit  = rem_sh >= den_reg;

    logic signed [SW-1:0] reward, tgt_sum, nq_sum, out_w;
    logic signed [18:0]   m_sum;
    logic [17:0]          p_up;
    logic [16:0]          p_new;
    logic [4:0]           nodes_c;

    always_comb begin
        case (reward_kind_t'(kind_reg))
            RWD_REACH:  reward = SW'(64'sd3014656);
            RWD_MIDWAY: reward = SW'(mob_reg);
            default:    reward = -SW'(64'sd1310720);
        endcase
        tgt_sum = reward + SW'(rnd);
        nq_sum  = SW'(q_rd_reg) + SW'(rnd);
        m_sum   = $signed({2'b00, m_rd_reg}) +
                  (neg_reg ? -$signed({2'b00, dq_reg}) : $signed({2'b00, dq_reg}));
        p_up    = {1'b0, p_rd_reg} + {1'b0, step_reg};
        if (col_reg == greedy_reg) begin
            p_new = (p_up > {1'b0, ONE_Q16}) ? ONE_Q16 : p_up[16:0];
        end else begin
            p_new = (p_rd_reg > dec_reg) ? p_rd_reg - dec_reg : 17'd0;
        end
        nodes_c = (an_reg < 5'd3) ? 5'd3 : an_reg;
        out_w   = SW'(nq_reg);
    end

    always_comb begin
        mul_a = 18'sd0;
        mul_b = BW'(best_reg);
        case (state_reg)
            ST_TGT:
            begin
                mul_a = $signed({1'b0, cap_one(dr_reg)});
                mul_b = BW'(best_reg);
            end
            ST_LR:
            begin
                mul_a = $signed({1'b0, cap_one(lr_reg)});
                mul_b = BW'(target_reg) - BW'(q_rd_reg);
            end
            ST_SMP:
            begin
                mul_a = $signed({1'b0, p_rd_reg});
                mul_b = BW'(q_rd_reg);
            end
            ST_SMM:
            begin
                mul_a = $signed({1'b0, m_rd_reg});
                mul_b = BW'(q_rd_reg);
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (row_reg == LAST && col_reg == LAST) state_next = ST_IDLE;
            ST_IDLE:  if (start) state_next = no_hop ? ST_DONE : ST_TGT;
            ST_TGT:   state_next = ST_TGT2;
            ST_TGT2:  state_next = ST_LR;
            ST_LR:    state_next = ST_NQ;
            ST_NQ:    state_next = ST_VIS;
            ST_VIS:   state_next = ST_MRD;
            ST_MRD:   state_next = ST_MLD;
            ST_MLD:   state_next = ST_MDIV;
            ST_MDIV:  if (cnt_reg == 5'd1) state_next = ST_MWR;
            ST_MWR:   state_next = (col_reg == LAST) ? ST_SRD : ST_MRD;
            ST_SRD:   state_next = ST_SMP;
            ST_SMP:   state_next = ST_SMM;
            ST_SMM:   state_next = ST_SACC;
            ST_SACC:  state_next = (col_reg == LAST) ? ST_DEC : ST_SRD;
            ST_DEC:   state_next = ST_DDIV;
            ST_DDIV:  if (cnt_reg == 5'd1) state_next = ST_URD;
            ST_URD:   state_next = ST_UWR;
            ST_UWR:   state_next = (col_reg == LAST) ? ST_DONE : ST_URD;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy       = state_reg != ST_IDLE;
        done       = state_reg == ST_DONE;
        skipped    = skip_reg;
        winning    = skip_reg ? 1'b0 : win_reg;
        greedy_hop = skip_reg ? 4'd0 : 4'(9'(greedy_reg));
        if (skip_reg) begin
            new_q = 32'sd0;
        end else if (out_w > O_HI) begin
            new_q = O_HI[31:0];
        end else if (out_w < O_LO) begin
            new_q = O_LO[31:0];
        end else begin
            new_q = out_w[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
            row_reg   <= '0;
            col_reg   <= '0;
            skip_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_CLEAR:
                begin
                    col_reg <= (col_reg == LAST) ? '0 : col_reg + 1'b1;
                    if (col_reg == LAST) row_reg <= (row_reg == LAST) ? '0 : row_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (start) begin
                        row_reg  <= mod_nodes(dest_index);
                        col_reg  <= mod_nodes(hop_index);
                        skip_reg <= no_hop;
                    end
                end
                ST_VIS:  col_reg <= '0;
                ST_MWR:  col_reg <= (col_reg == LAST) ? '0 : col_reg + 1'b1;
                ST_SACC: col_reg <= (col_reg == LAST) ? '0 : col_reg + 1'b1;
                ST_UWR:  col_reg <= (col_reg == LAST) ? '0 : col_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // datapath and tables
    always_ff @(posedge clk) begin
        q_rd_reg <= q_mem[addr];
        p_rd_reg <= p_mem[addr];
        m_rd_reg <= m_mem[addr];
        v_rd_reg <= v_mem[row_reg];
        prod_reg <= mul_p;
        case (state_reg)
            ST_CLEAR:
            begin
                q_mem[addr] <= '0;
                p_mem[addr] <= (row_reg == col_reg) ? 17'd0 : UNI;
                m_mem[addr] <= (row_reg == col_reg) ? 17'd0 : UNI;
                if (col_reg == '0) v_mem[row_reg] <= 16'd0;
            end
            ST_IDLE:
            begin
                kind_reg <= reward_kind;
                best_reg <= best_next_q;
                mob_reg  <= mobility_factor;
            end
            ST_TGT2: target_reg <= sat_q(tgt_sum);
            ST_NQ:
            begin
                nq_reg      <= sat_q(nq_sum);
                q_mem[addr] <= sat_q(nq_sum);
            end
            ST_VIS:
            begin
                vis_reg <= (v_rd_reg == 16'hFFFF) ? v_rd_reg : v_rd_reg + 16'd1;
                v_mem[row_reg] <= (v_rd_reg == 16'hFFFF) ? v_rd_reg : v_rd_reg + 16'd1;
                accp_reg <= '0;
                accm_reg <= '0;
            end
            ST_MLD:
            begin
                neg_reg <= m_rd_reg > p_rd_reg;
                dq_reg  <= (m_rd_reg > p_rd_reg) ? m_rd_reg - p_rd_reg : p_rd_reg - m_rd_reg;
                rem_reg <= '0;
                den_reg <= {1'b0, vis_reg};
                cnt_reg <= 5'd17;
            end
            ST_MDIV, ST_DDIV:
            begin
                rem_reg <= q_bit ? rem_sh - den_reg : rem_sh;
                dq_reg  <= {dq_reg[15:0], q_bit};
                cnt_reg <= cnt_reg - 5'd1;
                if (state_reg == ST_DDIV && cnt_reg == 5'd1) begin
                    dec_reg <= {dq_reg[15:0], q_bit};
                end
            end
            ST_MWR: m_mem[addr] <= m_sum[16:0];
            ST_SMP:
            begin
                if (col_reg == '0 || q_rd_reg > best_q_reg) begin
                    best_q_reg <= q_rd_reg;
                    greedy_reg <= col_reg;
                end
            end
            ST_SMM:  accp_reg <= accp_reg + AC'(prod_reg);
            ST_SACC: accm_reg <= accm_reg + AC'(prod_reg);
            ST_DEC:
            begin
                win_reg  <= accp_reg > accm_reg;
                step_reg <= cap_one((accp_reg > accm_reg) ? dw_reg : dl_reg);
                dq_reg   <= cap_one((accp_reg > accm_reg) ? dw_reg : dl_reg);
                rem_reg  <= '0;
                den_reg  <= 17'(nodes_c - 5'd2);
                cnt_reg  <= 5'd17;
            end
            ST_UWR: p_mem[addr] <= p_new;
            default: ;
        endcase
    end

endmodule
